[design/abvt_pkg.sv]
// Shared types and constants of the arcade bus glue and video timer.
// No dependencies.
`default_nettype none
package abvt_pkg;

	typedef enum logic [2:0] {
		MODE_MEM_RD   = 3'd0,
		MODE_MEM_WR   = 3'd1,
		MODE_IO_IN    = 3'd2,
		MODE_IO_OUT   = 3'd3,
		MODE_TICK     = 3'd4,
		MODE_INT_EN   = 3'd5,
		MODE_SET_BTN  = 3'd6,
		MODE_ROM_LOAD = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_ROM_WRITE = 2'd1,
		ST_MIRROR    = 2'd2,
		ST_BAD_PORT  = 2'd3
	} status_t;

	localparam logic [7:0] PORT_BTN_LAST   = 8'd2;
	localparam logic [7:0] PORT_SHIFT_AMT  = 8'd2;
	localparam logic [7:0] PORT_SHIFT_RD   = 8'd3;
	localparam logic [7:0] PORT_SOUND_A    = 8'd3;
	localparam logic [7:0] PORT_SHIFT_DATA = 8'd4;
	localparam logic [7:0] PORT_SOUND_B    = 8'd5;
	localparam logic [7:0] PORT_WATCHDOG   = 8'd6;

	localparam logic [15:0] WRAM_START  = 16'h2000;
	localparam logic [15:0] VRAM_BASE   = 16'h2400;
	localparam logic [15:0] MIRROR_BASE = 16'h4000;

	localparam logic [7:0] VEC_MID  = 8'hCF;
	localparam logic [7:0] VEC_VBL  = 8'hD7;
	localparam logic [8:0] LINE_MID = 9'd96;
	localparam logic [8:0] LINE_VBL = 9'd224;

	localparam int MEM_DEPTH = 16384;
	localparam int MEM_AW    = 14;

	// Remainder of v by d, valid for quotients below 8.
	function automatic logic [12:0] mod_small(input logic [12:0] v, input logic [13:0] d);
		logic [15:0] r;
		logic [15:0] m;
		r = {3'b0, v};
		for (int i = 2; i >= 0; i--) begin
			m = {2'b0, d} << i;
			if (r >= m) begin
				r = r - m;
			end
		end
		return r[12:0];
	endfunction

endpackage
`default_nettype wire

[design/abvt_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module abvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

[design/arcade_board_bus_and_video_timer_unit.sv]
// Bus glue, barrel shifter and beam timer of an 8080 arcade board.
// Each accepted beat passes the valid_s1 stage and then the output register; one item per
// cycle while m_tready is high, set by the single port of the shared ROM/RAM/video RAM memory.
// Reset: state registers clear at once; then a clearing pass zeroes all 8192 bytes of the
// RAM and video RAM region while s_tready stays low. ROM contents survive reset.
// Depends on abvt_pkg and abvt_ram.
`default_nettype none
module arcade_board_bus_and_video_timer_unit #(
	parameter int LINE_CLOCKS = 320,
	parameter int FRAME_LINES = 262,
	parameter int ROM_BYTES   = 8192,
	parameter int RAM_BYTES   = 1024,
	parameter int VRAM_BYTES  = 7168
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // address[15:0], data[23:16], tick_cycles[29:24]
	input  wire logic [2:0]  s_tuser,  // mode[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata   // read_data, int_vector, int_valid, frame_done, status
);
	import abvt_pkg::*;

	localparam logic [13:0] ROM_SIZE   = 14'(ROM_BYTES);
	localparam logic [13:0] WRAM_DEPTH = 14'(RAM_BYTES);
	localparam logic [13:0] VRAM_SIZE  = 14'(VRAM_BYTES);
	localparam logic [9:0]  LINE_LEN   = 10'(LINE_CLOCKS);
	localparam logic [9:0]  FRAME_LEN  = 10'(FRAME_LINES);

	mode_t       mode;
	logic [15:0] address;
	logic [7:0]  data;
	logic [5:0]  tick_cycles;
	logic [7:0]  port;
	logic        acc;
	logic        s1_adv;

	logic        clearing_q;
	logic [12:0] clr_idx_q;

	logic [15:0] shift_word_q, shift_word_d;
	logic [2:0]  shift_count_q, shift_count_d;
	logic [8:0]  column_q, column_d;
	logic [8:0]  line_q, line_d;
	logic        half_q, half_d;
	logic [7:0]  vec_q, vec_d;
	logic        flag_q, flag_d;
	logic [7:0]  btn_q [3];
	logic [7:0]  btn_d [3];

	logic        valid_s1;
	logic        use_mem_s1;
	logic [7:0]  rd_io_s1;
	logic [7:0]  vec_s1;
	logic        flag_s1;
	logic        frame_s1;
	status_t     status_s1;

	logic        m_valid_q;
	logic [23:0] m_data_q;

	logic                 mem_we, mem_re;
	logic [MEM_AW-1:0]    mem_addr;
	logic [7:0]           mem_wd, mem_rd;

	logic        use_mem;
	logic [7:0]  rd_io;
	logic        frame;
	status_t     status;
	logic [22:0] shifted;
	logic [8:0]  prod;
	logic        bump;
	logic [9:0]  col;
	logic [9:0]  line_inc;
	logic [12:0] rom_idx, ram_idx, vram_idx;
	logic [15:0] vram_off;
	logic        in_rom, in_vram, in_mirror;

	assign mode        = mode_t'(s_tuser);
	assign address     = s_tdata[15:0];
	assign data        = s_tdata[23:16];
	assign tick_cycles = s_tdata[29:24];
	assign port        = address[7:0];

	assign s1_adv   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !clearing_q && (!valid_s1 || s1_adv);
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign in_rom    = address < WRAM_START;
	assign in_mirror = address >= MIRROR_BASE;
	assign in_vram   = (address >= VRAM_BASE) && !in_mirror;
	assign vram_off  = address - VRAM_BASE;
	assign rom_idx   = mod_small(address[12:0], ROM_SIZE);
	assign ram_idx   = mod_small({3'b0, address[9:0]}, WRAM_DEPTH);
	assign vram_idx  = mod_small(vram_off[12:0], VRAM_SIZE);
	assign shifted   = {7'b0, shift_word_q} << shift_count_q;
	assign prod      = {1'b0, tick_cycles, 2'b0} + {3'b0, tick_cycles};
	assign bump      = half_q & tick_cycles[0];
	assign col       = {1'b0, column_q} + {2'b0, prod[8:1]} + {9'b0, bump};
	assign line_inc  = {1'b0, line_q} + 10'd1;

	always_comb begin
		mem_we        = 1'b0;
		mem_re        = 1'b0;
		mem_addr      = {1'b1, clr_idx_q};
		mem_wd        = 8'h00;
		use_mem       = 1'b0;
		rd_io         = 8'h00;
		frame         = 1'b0;
		status        = ST_OK;
		shift_word_d  = shift_word_q;
		shift_count_d = shift_count_q;
		column_d      = column_q;
		line_d        = line_q;
		half_d        = half_q;
		vec_d         = vec_q;
		flag_d        = flag_q;
		btn_d         = btn_q;
		if (clearing_q) begin
			mem_we = 1'b1;
		end else if (acc) begin
			case (mode)
				MODE_MEM_RD, MODE_MEM_WR: begin
					mem_wd = data;
					if (in_rom) begin
						mem_addr = {1'b0, rom_idx};
						if (mode == MODE_MEM_WR) begin
							status = ST_ROM_WRITE;
						end
					end else if (in_vram) begin
						mem_addr = 14'(VRAM_BASE) + {1'b0, vram_idx};
					end else begin
						mem_addr = 14'(WRAM_START) + {1'b0, ram_idx};
						if (in_mirror) begin
							status = ST_MIRROR;
						end
					end
					if (mode == MODE_MEM_RD) begin
						mem_re  = 1'b1;
						use_mem = 1'b1;
					end else begin
						mem_we = !in_rom;
					end
				end
				MODE_IO_IN: begin
					if (port <= PORT_BTN_LAST) begin
						rd_io = btn_q[port[1:0]];
					end else if (port == PORT_SHIFT_RD) begin
						rd_io = shifted[15:8];
					end else begin
						status = ST_BAD_PORT;
					end
				end
				MODE_IO_OUT: begin
					if (port == PORT_SHIFT_AMT) begin
						shift_count_d = data[2:0];
					end else if (port == PORT_SHIFT_DATA) begin
						shift_word_d = {data, shift_word_q[15:8]};
					end else if (port == PORT_SOUND_A || port == PORT_SOUND_B ||
						port == PORT_WATCHDOG) begin
						status = ST_OK;
					end else begin
						status = ST_BAD_PORT;
					end
				end
				MODE_TICK: begin
					half_d   = bump ? 1'b0 : (half_q | tick_cycles[0]);
					column_d = col[8:0];
					if (col >= LINE_LEN) begin
						column_d = 9'(col - LINE_LEN);
						line_d   = line_inc[8:0];
						if (line_inc >= FRAME_LEN) begin
							line_d = 9'd0;
							frame  = 1'b1;
						end
						if (line_d == LINE_MID) begin
							vec_d  = VEC_MID;
							flag_d = 1'b1;
						end else if (line_d == LINE_VBL) begin
							vec_d  = VEC_VBL;
							flag_d = 1'b1;
						end
					end
				end
				MODE_INT_EN: begin
					if (data[0]) begin
						vec_d  = 8'h00;
						flag_d = 1'b0;
					end
				end
				MODE_SET_BTN: begin
					if (address <= 16'(PORT_BTN_LAST)) begin
						btn_d[address[1:0]] = data;
					end else begin
						status = ST_BAD_PORT;
					end
				end
				MODE_ROM_LOAD: begin
					mem_addr = {1'b0, address[12:0]};
					mem_wd   = data;
					mem_we   = address < 16'(ROM_SIZE);
				end
				default: begin
					status = ST_OK;
				end
			endcase
		end
	end

	abvt_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wd),
		.rdata (mem_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q    <= 1'b1;
			clr_idx_q     <= '0;
			shift_word_q  <= '0;
			shift_count_q <= '0;
			column_q      <= '0;
			line_q        <= '0;
			half_q        <= 1'b0;
			vec_q         <= '0;
			flag_q        <= 1'b0;
			btn_q         <= '{default: 8'h00};
			valid_s1      <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 13'd1;
				if (&clr_idx_q) begin
					clearing_q <= 1'b0;
				end
			end
			shift_word_q  <= shift_word_d;
			shift_count_q <= shift_count_d;
			column_q      <= column_d;
			line_q        <= line_d;
			half_q        <= half_d;
			vec_q         <= vec_d;
			flag_q        <= flag_d;
			btn_q         <= btn_d;
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			use_mem_s1 <= use_mem;
			rd_io_s1   <= rd_io;
			vec_s1     <= flag_d ? vec_d : 8'h00;
			flag_s1    <= flag_d;
			frame_s1   <= frame;
			status_s1  <= status;
		end
		if (s1_adv) begin
			m_data_q <= {4'b0000, status_s1, frame_s1, flag_s1, vec_s1,
				use_mem_s1 ? mem_rd : rd_io_s1};
		end
	end

endmodule
`default_nettype wire

[tb/sv/abvt_scoreboard_pkg.sv]
// Scoreboard for the arcade bus glue and video timer: tracks memory, ports,
// shifter and beam state to predict each reply beat and checks the DUT against it.
// Depends on abvt_pkg.
`timescale 1ns / 1ps
package abvt_scoreboard_pkg;
	import abvt_pkg::*;

	localparam int LINE_CLOCKS = 320;
	localparam int FRAME_LINES = 262;
	localparam int ROM_SIZE    = 8192;
	localparam int WRAM_DEPTH  = 1024;
	localparam int VRAM_SIZE   = 7168;

	typedef struct packed {
		logic [3:0] pad;
		status_t    status;
		logic       frame_done;
		logic       int_valid;
		logic [7:0] int_vector;
		logic [7:0] read_data;
	} bus_reply_t;

	class board_scoreboard;
		bit [7:0]   rom_image [ROM_SIZE];
		bit [7:0]   work_ram [WRAM_DEPTH];
		bit [7:0]   video_ram [VRAM_SIZE];
		bit [7:0]   buttons [3];
		bit [15:0]  shift_word;
		bit [2:0]   shift_count;
		int         beam_column;
		int         beam_line;
		bit         half_carry;
		bit [7:0]   irq_vector;
		bit         irq_pending;
		bus_reply_t expected_replies [$];
		int         errors;

		function int outstanding();
			return expected_replies.size();
		endfunction

		function void take_request(mode_t mode, logic [15:0] addr, logic [7:0] data,
				logic [5:0] cycles);
			bus_reply_t r;
			logic [7:0] port;
			logic [23:0] shifted;
			int pixels;
			int col;
			r = '0;
			port = addr[7:0];
			r.status = ST_OK;
			case (mode)
				MODE_MEM_RD: begin
					if (addr < WRAM_START) begin
						r.read_data = rom_image[addr[12:0]];
					end else if (addr >= VRAM_BASE && addr < MIRROR_BASE) begin
						r.read_data = video_ram[addr - VRAM_BASE];
					end else begin
						if (addr >= MIRROR_BASE) r.status = ST_MIRROR;
						r.read_data = work_ram[addr[9:0]];
					end
				end
				MODE_MEM_WR: begin
					if (addr < WRAM_START) begin
						r.status = ST_ROM_WRITE;
					end else if (addr >= VRAM_BASE && addr < MIRROR_BASE) begin
						video_ram[addr - VRAM_BASE] = data;
					end else begin
						if (addr >= MIRROR_BASE) r.status = ST_MIRROR;
						work_ram[addr[9:0]] = data;
					end
				end
				MODE_IO_IN: begin
					if (port <= PORT_BTN_LAST) begin
						r.read_data = buttons[port];
					end else if (port == PORT_SHIFT_RD) begin
						shifted = {8'h00, shift_word} << shift_count;
						r.read_data = shifted[15:8];
					end else begin
						r.status = ST_BAD_PORT;
					end
				end
				MODE_IO_OUT: begin
					if (port == PORT_SHIFT_AMT) begin
						shift_count = data[2:0];
					end else if (port == PORT_SHIFT_DATA) begin
						shift_word = {data, shift_word[15:8]};
					end else if (port != PORT_SOUND_A && port != PORT_SOUND_B &&
							port != PORT_WATCHDOG) begin
						r.status = ST_BAD_PORT;
					end
				end
				MODE_TICK: begin
					pixels = int'(cycles) * 5 / 2;
					if (cycles[0]) begin
						if (half_carry) begin
							half_carry = 1'b0;
							pixels++;
						end else begin
							half_carry = 1'b1;
						end
					end
					col = beam_column + pixels;
					if (col >= LINE_CLOCKS) begin
						col -= LINE_CLOCKS;
						beam_line++;
						if (beam_line >= FRAME_LINES) begin
							beam_line = 0;
							r.frame_done = 1'b1;
						end
						if (beam_line == LINE_MID) begin
							irq_vector = VEC_MID;
							irq_pending = 1'b1;
						end else if (beam_line == LINE_VBL) begin
							irq_vector = VEC_VBL;
							irq_pending = 1'b1;
						end
					end
					beam_column = col;
				end
				MODE_INT_EN: begin
					if (data[0]) begin
						irq_pending = 1'b0;
						irq_vector = '0;
					end
				end
				MODE_SET_BTN: begin
					if (addr <= PORT_BTN_LAST) buttons[addr] = data;
					else r.status = ST_BAD_PORT;
				end
				MODE_ROM_LOAD: begin
					if (addr < ROM_SIZE) rom_image[addr] = data;
				end
			endcase
			r.int_valid = irq_pending;
			r.int_vector = irq_pending ? irq_vector : 8'h00;
			expected_replies.insert(expected_replies.size(), r);
		endfunction

		function void compare_field(string name, logic [7:0] exp, logic [7:0] got);
			if (got !== exp) begin
				errors++;
				$display("%0t: %s expected %02h got %02h", $time, name, exp, got);
			end
		endfunction

		function void check_reply(logic [23:0] beat);
			bus_reply_t got;
			bus_reply_t exp;
			got = bus_reply_t'(beat);
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply, expected none got %06h", $time, beat);
				return;
			end
			exp = expected_replies.pop_front();
			compare_field("read_data", exp.read_data, got.read_data);
			compare_field("int_vector", exp.int_vector, got.int_vector);
			compare_field("int_valid", exp.int_valid, got.int_valid);
			compare_field("frame_done", exp.frame_done, got.frame_done);
			compare_field("status", exp.status, got.status);
			compare_field("pad", exp.pad, got.pad);
		endfunction
	endclass

endpackage

[tb/sv/tb_top.sv]
// Top-level testbench of arcade_board_bus_and_video_timer_unit: drives bus and tick
// beats under varying idle and stall patterns, checks every reply beat.
// Depends on abvt_pkg, abvt_scoreboard_pkg and the DUT.
`timescale 1ns / 1ps
module tb_top;
	import abvt_pkg::*;
	import abvt_scoreboard_pkg::*;

	// covers the post-reset clearing pass plus long random stalls
	localparam int STUCK_LIMIT = 40000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = MODE_MEM_RD;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	int idle_pct = 0;
	int stall_pct = 0;
	int stuck_cycles = 0;

	board_scoreboard tracker = new;
	bit              rom_loaded [ROM_SIZE];
	logic [15:0]     rom_addrs [$];
	logic [15:0]     recent_writes [$];

	arcade_board_bus_and_video_timer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) tracker.check_reply(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic send_beat(mode_t mode, logic [15:0] addr, logic [7:0] data,
			logic [5:0] cycles);
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {2'b00, cycles, data, addr};
		do @(posedge clk); while (!s_tready);
		tracker.take_request(mode, addr, data, cycles);
		if (mode == MODE_ROM_LOAD && addr < ROM_SIZE && !rom_loaded[addr[12:0]]) begin
			rom_loaded[addr[12:0]] = 1'b1;
			rom_addrs.insert(rom_addrs.size(), addr);
		end
		if (mode == MODE_MEM_WR && addr >= WRAM_START) begin
			recent_writes.insert(recent_writes.size(), addr);
			if (recent_writes.size() > 64) void'(recent_writes.pop_front());
		end
	endtask

	function automatic logic [15:0] mem_address();
		case ($urandom_range(3))
			0: return WRAM_START + 16'($urandom_range(WRAM_DEPTH - 1));
			1: return VRAM_BASE + 16'($urandom_range(VRAM_SIZE - 1));
			2: return 16'($urandom_range(16'hFFFF, MIRROR_BASE));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] port_address();
		logic [15:0] a;
		a = 16'($urandom);
		if ($urandom_range(3) != 0) a[7:0] = 8'($urandom_range(7));
		return a;
	endfunction

	task automatic random_beat();
		int pick;
		logic [15:0] a;
		logic [7:0] d;
		logic [5:0] c;
		mode_t m;
		pick = $urandom_range(99);
		a = 16'($urandom);
		d = 8'($urandom);
		c = 6'($urandom);
		if (pick < 50) begin
			m = MODE_TICK;
			if ($urandom_range(3) != 0) c = 6'($urandom_range(63, 52));
		end else if (pick < 60) begin
			m = MODE_MEM_WR;
			a = mem_address();
		end else if (pick < 71) begin
			m = MODE_MEM_RD;
			if (recent_writes.size() > 0 && $urandom_range(1) == 1) begin
				a = recent_writes[$urandom_range(recent_writes.size() - 1)];
			end else if (rom_addrs.size() > 0 && $urandom_range(3) == 0) begin
				a = rom_addrs[$urandom_range(rom_addrs.size() - 1)];
			end else begin
				a = mem_address();
				// steer unloaded ROM reads into RAM / video RAM
				if (a < WRAM_START && !rom_loaded[a[12:0]]) a[13] = 1'b1;
			end
		end else if (pick < 78) begin
			m = MODE_IO_IN;
			a = port_address();
		end else if (pick < 86) begin
			m = MODE_IO_OUT;
			a = port_address();
		end else if (pick < 89) begin
			m = MODE_INT_EN;
		end else if (pick < 94) begin
			m = MODE_SET_BTN;
			if ($urandom_range(3) != 0) a = 16'($urandom_range(3));
		end else begin
			m = MODE_ROM_LOAD;
			if ($urandom_range(3) != 0) a = 16'($urandom_range(ROM_SIZE - 1));
		end
		send_beat(m, a, d, c);
	endtask

	initial begin
		int idle_plan [4];
		int stall_plan [4];
		idle_plan = '{0, 88, 0, 22};
		stall_plan = '{0, 0, 88, 22};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_beat(MODE_MEM_RD, 16'h2000, 8'h00, 6'd0);
		send_beat(MODE_MEM_WR, 16'h23FF, 8'hFF, 6'd63);
		send_beat(MODE_MEM_WR, 16'h4000, 8'h5A, 6'd0);
		send_beat(MODE_MEM_RD, 16'hE3FF, 8'h00, 6'd0);
		send_beat(MODE_MEM_RD, 16'hFFFF, 8'h00, 6'd0);
		send_beat(MODE_MEM_RD, 16'h2000, 8'h00, 6'd0);
		send_beat(MODE_MEM_WR, 16'h2400, 8'h11, 6'd0);
		send_beat(MODE_MEM_WR, 16'h3FFF, 8'h80, 6'd0);
		send_beat(MODE_MEM_RD, 16'h3FFF, 8'h00, 6'd0);
		send_beat(MODE_MEM_WR, 16'h0000, 8'h33, 6'd0);
		send_beat(MODE_ROM_LOAD, 16'h1FFF, 8'hFF, 6'd0);
		send_beat(MODE_ROM_LOAD, 16'h0000, 8'h01, 6'd0);
		send_beat(MODE_ROM_LOAD, 16'hFFFF, 8'hEE, 6'd0);
		send_beat(MODE_MEM_RD, 16'h1FFF, 8'h00, 6'd0);
		send_beat(MODE_MEM_RD, 16'h0000, 8'h00, 6'd0);
		send_beat(MODE_IO_OUT, 16'h0002, 8'hFF, 6'd0);
		send_beat(MODE_IO_OUT, 16'h0004, 8'hFF, 6'd0);
		send_beat(MODE_IO_OUT, 16'hFF04, 8'h01, 6'd0);
		send_beat(MODE_IO_IN, 16'h0003, 8'h00, 6'd0);
		send_beat(MODE_SET_BTN, 16'h0002, 8'h81, 6'd0);
		send_beat(MODE_SET_BTN, 16'hFFFF, 8'h7E, 6'd0);
		send_beat(MODE_IO_IN, 16'h0102, 8'h00, 6'd0);
		send_beat(MODE_IO_IN, 16'h00FF, 8'h00, 6'd0);
		send_beat(MODE_IO_OUT, 16'h0007, 8'h55, 6'd0);
		send_beat(MODE_IO_OUT, 16'h1203, 8'hAA, 6'd0);
		send_beat(MODE_IO_OUT, 16'h0005, 8'hAA, 6'd0);
		send_beat(MODE_IO_OUT, 16'h0006, 8'hAA, 6'd0);
		send_beat(MODE_TICK, 16'h0000, 8'h00, 6'd63);
		send_beat(MODE_TICK, 16'h0000, 8'h00, 6'd63);
		send_beat(MODE_TICK, 16'h0000, 8'h00, 6'd0);
		send_beat(MODE_INT_EN, 16'h0000, 8'hFE, 6'd0);
		send_beat(MODE_INT_EN, 16'h0000, 8'h01, 6'd0);

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			repeat (405) random_beat();
		end
		s_tvalid <= 1'b0;

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
